// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define TBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/tbe_pkg.sv -----
// Types and constants of the bandwidth estimator.
`timescale 1ns / 1ps
package tbe_pkg;

  // field widths
  localparam int TIME_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int CNT_W      = 16;
  localparam int UPT_W      = 14;
  localparam int MSS_W      = 16;
  localparam int BW_W       = 32;
  localparam int METHOD_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // size * 1e6 fits 36 bits; dividing by delta * 1024 drops 10 low bits first
  localparam int NUM_W      = 36;
  localparam int KB_SHIFT   = 10;
  localparam int DIVIDEND_W = NUM_W - KB_SHIFT;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  // rtt_d * 50 product width
  localparam int RTT50_W = 38;

  // divide by 10 through a reciprocal, exact for 16-bit values
  localparam int TENTH_W     = 13;
  localparam int TENTH_LSB   = 19;
  localparam int TENTH_PROD_W = SIZE_W + 17;

  localparam logic [MUL_B_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [MUL_B_W-1:0] RTT_FRAC     = 20'd50;
  localparam logic [16:0]        RECIP_TENTH  = 17'd52429;
  localparam logic [CNT_W-1:0]   CWND_MIN     = 16'd2;

  localparam logic [UPT_W-1:0] UPT_RESET = 14'd4000;
  localparam logic [MSS_W-1:0] MSS_RESET = 16'd1460;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USEC_PER_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSS_BYTES     = 2'd1;

  typedef enum logic [METHOD_W-1:0] {
    METHOD_NONE = 2'd0,
    METHOD_PAIR = 2'd1,
    METHOD_RATE = 2'd2
  } method_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RTT,
    ST_MUL_START,
    ST_MUL_CMP,
    ST_MUL_NUM,
    ST_DECIDE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/tbe_req_if.sv -----
// Request channel: one acknowledgement event.
`timescale 1ns / 1ps
interface tbe_req_if;
  import tbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] echo_ticks;
  logic [SIZE_W-1:0] seg_size;
  logic [CNT_W-1:0]  packets_in_flight;
  logic [CNT_W-1:0]  cwnd_packets;

  modport source (output valid, now_ticks, echo_ticks, seg_size, packets_in_flight,
                  cwnd_packets, input ready);
  modport sink (input valid, now_ticks, echo_ticks, seg_size, packets_in_flight,
                cwnd_packets, output ready);
endinterface

// ----- rtl/tbe_rsp_if.sv -----
// Result channel: estimate, method and measured RTT.
`timescale 1ns / 1ps
interface tbe_rsp_if;
  import tbe_pkg::*;

  logic                valid;
  logic                ready;
  logic [BW_W-1:0]     bandwidth_kbps;
  logic [METHOD_W-1:0] method;
  logic [TIME_W-1:0]   rtt_usec;

  modport source (output valid, bandwidth_kbps, method, rtt_usec, input ready);
  modport sink (input valid, bandwidth_kbps, method, rtt_usec, output ready);
endinterface

// ----- rtl/tcp_bandwidth_estimator_core.sv -----
// Top level of the acknowledgement-driven bandwidth estimator.
// Each accepted request is one acknowledgement; it yields exactly one result with
// the held estimate in KB/s, the method that updated it (none, packet pair or
// rate based) and the RTT just measured. Every request makes four passes through
// the shared 32x20 multiplier (RTT, start time, RTT slope bound, size scaling)
// and then a decision step. When the estimate is updated, a 26-step restoring
// divide follows, and its done pulse moves the sequencer on to the finish step.
// With no update the finish step follows the decision step directly. The block
// takes no new request until that result has been loaded into the output
// register, so a request holds the block through any wait for the result side.
// The output register lets the next request be accepted while a result waits.
// The user must write configuration through cfg_wen/cfg_index/cfg_wdata while
// idle; the block itself does not enforce it. An unknown index is ignored.
// No clearing pass after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcp_bandwidth_estimator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [tbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  tbe_req_if.sink                          req,
  tbe_rsp_if.source                        rsp
);
  import tbe_pkg::*;

  state_t state, state_next;

  // configuration
  logic [UPT_W-1:0] upt;
  logic [MSS_W-1:0] mss;

  // estimator state
  logic [TIME_W-1:0] prev_rtt, prev_start, cur_rtt, cur_start;
  logic [SIZE_W-1:0] prev_size, cur_size;
  logic [BW_W-1:0]   estimate;
  method_t           method_r, method_next;

  // per-request operands
  logic [TIME_W-1:0]  dt;
  logic [TIME_W-1:0]  echo;
  logic [CNT_W-1:0]   pif;
  logic [CNT_W-1:0]   cwnd;
  logic [RTT50_W-1:0] rtt50;

  // shared units
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_P_W-1:0]    mul_prod;
  logic                  div_start;
  logic [TIME_W-1:0]     div_divisor;
  logic [DIVIDEND_W-1:0] div_quo;
  div_stat_t             div_stat;

  // decision terms
  logic [TIME_W-1:0]       rtt_d, start_d, spacing;
  logic [TENTH_PROD_W-1:0] tenth_prod;
  logic [TENTH_W-1:0]      tenth;
  logic signed [SIZE_W:0]  size_diff, tenth_s;
  logic [20:0]             mss9, size_p1, size10;
  logic both, close_sizes, close_sends, rtt_ok, cwnd_ok, mss_ok;
  logic pair_path, rate_path, go_div;
  logic req_ready;
  logic accept;

  assign accept    = req.valid && req_ready;
  assign req.ready = req_ready;

  tbe_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  tbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod[NUM_W-1:KB_SHIFT]),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // packet-pair and rate conditions
  always_comb begin
    rtt_d       = cur_rtt - prev_rtt;
    start_d     = cur_start - prev_start;
    spacing     = (cur_start + cur_rtt) - (prev_start + prev_rtt);
    tenth_prod  = TENTH_PROD_W'(cur_size) * TENTH_PROD_W'(RECIP_TENTH);
    tenth       = tenth_prod[TENTH_LSB +: TENTH_W];
    size_diff   = $signed({1'b0, cur_size}) - $signed({1'b0, prev_size});
    tenth_s     = $signed({(SIZE_W + 1 - TENTH_W)'(0), tenth});
    both        = (cur_size != '0) && (prev_size != '0);
    close_sizes = (size_diff < tenth_s) && (size_diff > -tenth_s);
    close_sends = start_d < TIME_W'(tenth);
    // rtt_d < rtt / 50  <=>  50 * rtt_d + 50 <= rtt
    rtt_ok      = ({1'b0, rtt50} + (RTT50_W + 1)'(RTT_FRAC))
                  <= (RTT50_W + 1)'(cur_rtt);
    cwnd_ok     = (cwnd >= CWND_MIN) && (pif >= cwnd - CWND_MIN);
    // size >= 9 * mss / 10  <=>  9 * mss < 10 * (size + 1)
    mss9        = (21'(mss) << 3) + 21'(mss);
    size_p1     = 21'(cur_size) + 21'd1;
    size10      = (size_p1 << 3) + (size_p1 << 1);
    mss_ok      = mss9 < size10;
    pair_path   = both && close_sizes && close_sends;
    rate_path   = !close_sends && both && cwnd_ok && rtt_ok;
    go_div      = pair_path ? (rtt_d != '0)
                            : (rate_path && spacing != '0 && mss_ok);
    div_divisor = pair_path ? rtt_d : spacing;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, multiplier operands, unit controls
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    div_start   = 1'b0;
    method_next = method_r;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          state_next = ST_MUL_RTT;
        end
      end
      ST_MUL_RTT: begin
        mul_a      = dt;
        mul_b      = MUL_B_W'(upt);
        state_next = ST_MUL_START;
      end
      ST_MUL_START: begin
        mul_a      = echo;
        mul_b      = MUL_B_W'(upt);
        state_next = ST_MUL_CMP;
      end
      ST_MUL_CMP: begin
        mul_a      = rtt_d;
        mul_b      = RTT_FRAC;
        state_next = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        mul_a      = MUL_A_W'(cur_size);
        mul_b      = USEC_PER_SEC;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        div_start = go_div;
        if (go_div) begin
          method_next = pair_path ? METHOD_PAIR : METHOD_RATE;
          state_next  = ST_DIVIDE;
        end else begin
          method_next = METHOD_NONE;
          state_next  = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upt <= UPT_RESET;
      mss <= MSS_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_USEC_PER_TICK: upt <= cfg_wdata[UPT_W-1:0];
        CFG_MSS_BYTES:     mss <= cfg_wdata[MSS_W-1:0];
        default: ;
      endcase
    end
  end

  // estimator history and held estimate
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rtt   <= '0;
      prev_start <= '0;
      prev_size  <= '0;
      cur_rtt    <= '0;
      cur_start  <= '0;
      cur_size   <= '0;
      estimate   <= '0;
      method_r   <= METHOD_NONE;
    end else begin
      method_r <= method_next;
      if (accept) begin
        prev_rtt   <= cur_rtt;
        prev_start <= cur_start;
        prev_size  <= cur_size;
        cur_size   <= req.seg_size;
      end
      if (state == ST_MUL_START) begin
        cur_rtt <= mul_prod[TIME_W-1:0];
      end
      if (state == ST_MUL_CMP) begin
        cur_start <= mul_prod[TIME_W-1:0];
      end
      if (state == ST_DIVIDE && div_stat.done) begin
        estimate <= BW_W'(div_quo);
      end
    end
  end

  // request operands and intermediate products
  always_ff @(posedge clk) begin
    if (accept) begin
      dt   <= req.now_ticks - req.echo_ticks;
      echo <= req.echo_ticks;
      pif  <= req.packets_in_flight;
      cwnd <= req.cwnd_packets;
    end
    if (state == ST_MUL_NUM) begin
      rtt50 <= mul_prod[RTT50_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.bandwidth_kbps <= estimate;
      rsp.method         <= method_r;
      rsp.rtt_usec       <= cur_rtt;
    end
  end

  `TBE_ASSERT_IMP(a_div_in_divide, div_stat.busy, state == ST_DIVIDE,
                  "divider running outside the divide step")
  `TBE_ASSERT_IMP(a_rsp_method, rsp.valid,
                  rsp.method == METHOD_NONE || rsp.method == METHOD_PAIR ||
                  rsp.method == METHOD_RATE, "result carries an unknown method")

endmodule

// ----- rtl/tbe_mul.sv -----
// Shared multiplier with registered product.
`timescale 1ns / 1ps
module tbe_mul (
  input  logic                   clk,
  input  logic [tbe_pkg::MUL_A_W-1:0] a,
  input  logic [tbe_pkg::MUL_B_W-1:0] b,
  output logic [tbe_pkg::MUL_P_W-1:0] prod
);
  import tbe_pkg::*;

  // one product per cycle, registered, result available in the next cycle
  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ----- rtl/tbe_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tbe_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [tbe_pkg::TIME_W-1:0]     divisor,
  output logic [tbe_pkg::DIVIDEND_W-1:0] quotient,
  output tbe_pkg::div_stat_t             stat
);
  import tbe_pkg::*;

  logic [TIME_W-1:0]     rem;
  logic [TIME_W-1:0]     dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [STEP_W-1:0]     step;
  logic                  busy;
  logic                  done;

  logic [TIME_W:0] trial;
  logic [TIME_W:0] trial_sub;
  logic            fits;

  // trial subtract of the shifted remainder
  always_comb begin
    trial     = {rem, quo[DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  `TBE_ASSERT_IMP(a_no_restart, start, !busy, "divider started while busy")
  `TBE_ASSERT_IMP(a_last_step_done, busy && step == STEP_W'(DIVIDEND_W - 1) && !start,
                  ##1 done, "divider missed its done pulse")

endmodule
